### design/mfr_pkg.sv
// Shared types, codes and constants for the Manchester frame receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;

  localparam int FRAME_BITS = 32;
  localparam int WORD_W     = 32;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);

  // opcodes carried on in_tuser
  localparam logic [1:0] OP_ARM   = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;
  localparam logic [1:0] OP_POLL  = 2'd3;

  // receive phases
  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_RECV    = 3'd2;
  localparam logic [2:0] PH_READY   = 3'd3;
  localparam logic [2:0] PH_INVALID = 3'd4;

  // result status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_PARITY    = 3'd2;
  localparam logic [2:0] ST_DATA_INV  = 3'd3;
  localparam logic [2:0] ST_UNK_ID    = 3'd4;
  localparam logic [2:0] ST_UNK_ERR   = 3'd5;
  localparam logic [2:0] ST_FRAMING   = 3'd6;
  localparam logic [2:0] ST_TIMEOUT   = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_MASTER_MODE = 2'd0;
  localparam logic [1:0] CFG_BIT_GAP     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [15:0] BIT_GAP_RST = 16'd750;
  localparam logic [31:0] TIMEOUT_RST = 32'd800000;

  typedef struct packed {
    logic        master_mode;
    logic [15:0] bit_gap_us;
    logic [31:0] response_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] frame_word;
    logic [2:0]        phase;
  } res_t;

endpackage
`default_nettype wire

### design/manchester_frame_receiver.sv
// Manchester frame receiver: top level with input and result registers.
// Depends on mfr_pkg, mfr_cfg, mfr_rx_core (which holds mfr_classify).
//
// Usage:
//   Input words carry an opcode on in_tuser (arm, line edge, abort, timeout
//   poll) and a microsecond timestamp plus line level on in_tdata. Every
//   input word produces exactly one result word: status on out_tuser, and
//   the frame, its type, id and value fields and the receive phase on
//   out_tdata.
//   A word taken into the input register is processed into the result
//   register once it is free or being read, and the result is then valid.
//   Throughput: one word per cycle; the phase/bit-count state loop closes in
//   the single processing stage between the input and result registers.
//   The result register frees the input side: a new word is taken while a
//   result waits, as long as the input register can move on.
//   When out_tready is low the result holds, the input register fills and
//   in_tready drops; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties both registers, puts the receiver
//   in the invalid phase and loads the configuration defaults (master mode,
//   750 us bit gap, 800000 us response timeout). An arm word starts a frame.
//   Configuration writes via cfg_we/cfg_addr/cfg_wdata are registered.
`timescale 1ns / 1ps
`default_nettype none
module manchester_frame_receiver (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // time_us[31:0], line_level[32], zero pad
  input  wire logic [1:0]   in_tuser,   // opcode[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // frame_word[31:0], message_type[34:32],
                                        // data_id[42:35], data_value[58:43],
                                        // phase[61:59], zero pad
  output logic [2:0]        out_tuser,  // status[2:0]
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  mfr_pkg::cfg_t cfg;
  mfr_pkg::res_t res;

  logic        in_v_r;
  logic [1:0]  op_r;
  logic [31:0] time_r;
  logic        level_r;
  logic        out_v_r;
  logic [2:0]  status_r;
  logic [31:0] word_r;
  logic [2:0]  phase_r;
  logic        advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  mfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mfr_rx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .advance    (advance),
    .opcode     (op_r),
    .time_us    (time_r),
    .line_level (level_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      time_r  <= in_tdata[31:0];
      level_r <= in_tdata[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= res.status;
      word_r   <= res.frame_word;
      phase_r  <= res.phase;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, phase_r, word_r[15:0], word_r[23:16], word_r[30:28], word_r};

  // classified status exactly when the frame is ready
  a_ready_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((phase_r == mfr_pkg::PH_READY) ==
                 (status_r != mfr_pkg::ST_BUSY && status_r != mfr_pkg::ST_FRAMING &&
                  status_r != mfr_pkg::ST_TIMEOUT)))
    else $error("status does not match ready phase");

  a_fault_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (status_r == mfr_pkg::ST_FRAMING || status_r == mfr_pkg::ST_TIMEOUT))
      |-> (phase_r == mfr_pkg::PH_INVALID))
    else $error("fault status without invalid phase");

  a_busy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && status_r == mfr_pkg::ST_BUSY) |-> (word_r == '0))
    else $error("frame fields not cleared on busy status");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled while result register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed word produced no result");

endmodule
`default_nettype wire

### design/mfr_cfg.sv
// Configuration register file for the Manchester frame receiver.
// Depends on mfr_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none
module mfr_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  output mfr_pkg::cfg_t     cfg
);

  mfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_mode         <= 1'b1;
      cfg_r.bit_gap_us          <= mfr_pkg::BIT_GAP_RST;
      cfg_r.response_timeout_us <= mfr_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mfr_pkg::CFG_MASTER_MODE: cfg_r.master_mode         <= cfg_wdata[0];
        mfr_pkg::CFG_BIT_GAP:     cfg_r.bit_gap_us          <= cfg_wdata[15:0];
        mfr_pkg::CFG_TIMEOUT:     cfg_r.response_timeout_us <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### design/mfr_classify.sv
// Frame classifier: even parity over the word plus message type check.
// Depends on mfr_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none
module mfr_classify (
  input  wire logic [mfr_pkg::WORD_W-1:0] frame_word,
  output logic [2:0]                      status
);

  logic       odd;
  logic [2:0] mtype;

  assign odd   = ^frame_word;
  assign mtype = frame_word[30:28];

  always_comb begin
    if (odd) begin
      status = mfr_pkg::ST_PARITY;
    end else begin
      case (mtype)
        3'd0, 3'd1, 3'd4, 3'd5: status = mfr_pkg::ST_OK;
        3'd2, 3'd6:             status = mfr_pkg::ST_DATA_INV;
        3'd7:                   status = mfr_pkg::ST_UNK_ID;
        default:                status = mfr_pkg::ST_UNK_ERR;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/mfr_rx_core.sv
// Receive state machine: phase, edge timing, bit shifter and send time.
// Depends on mfr_pkg and mfr_classify; updates state once per advanced word.
`timescale 1ns / 1ps
`default_nettype none
module mfr_rx_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mfr_pkg::cfg_t cfg,
  input  wire logic          advance,
  input  wire logic [1:0]    opcode,
  input  wire logic [31:0]   time_us,
  input  wire logic          line_level,
  output mfr_pkg::res_t      res
);

  logic [2:0]                     phase_r, phase_nxt, edge_phase;
  logic [31:0]                    last_r, last_nxt;
  logic [mfr_pkg::BITS_W-1:0]     bits_r, bits_nxt;
  logic [mfr_pkg::WORD_W-1:0]     shift_r, shift_nxt;
  logic [31:0]                    send_r, send_nxt;
  logic [2:0]                     ev_status, cls_status;
  logic [31:0]                    gap, since_send;
  logic [31:0]                    bit_gap;
  logic                           edge_taken;

  assign gap        = time_us - last_r;
  assign since_send = time_us - send_r;
  assign bit_gap    = {16'd0, cfg.bit_gap_us};

  // a ready frame in slave mode restarts on a high edge
  assign edge_taken = (phase_r != mfr_pkg::PH_INVALID) &&
                      !(phase_r == mfr_pkg::PH_READY && (cfg.master_mode || !line_level));
  assign edge_phase = (phase_r == mfr_pkg::PH_READY) ? mfr_pkg::PH_WAIT : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    send_nxt  = send_r;
    ev_status = mfr_pkg::ST_BUSY;
    unique case (opcode)
      mfr_pkg::OP_ARM: begin
        shift_nxt = '0;
        phase_nxt = mfr_pkg::PH_WAIT;
        send_nxt  = time_us;
      end
      mfr_pkg::OP_EDGE: begin
        if (edge_taken) begin
          if (phase_r == mfr_pkg::PH_READY) begin
            shift_nxt = '0;
          end
          unique case (edge_phase)
            mfr_pkg::PH_WAIT: begin
              if (line_level) begin
                last_nxt  = time_us;
                bits_nxt  = mfr_pkg::BITS_W'(mfr_pkg::FRAME_BITS);
                phase_nxt = mfr_pkg::PH_START;
              end else begin
                phase_nxt = mfr_pkg::PH_INVALID;
                ev_status = mfr_pkg::ST_FRAMING;
              end
            end
            mfr_pkg::PH_START: begin
              if (gap < bit_gap && !line_level) begin
                last_nxt  = time_us;
                phase_nxt = mfr_pkg::PH_RECV;
              end else begin
                phase_nxt = mfr_pkg::PH_INVALID;
                ev_status = mfr_pkg::ST_FRAMING;
              end
            end
            default: begin
              // receiving: closely spaced edges are mid-bit transitions
              if (gap > bit_gap) begin
                if (bits_r != '0) begin
                  shift_nxt = {shift_r[mfr_pkg::WORD_W-2:0], ~line_level};
                  last_nxt  = time_us;
                  bits_nxt  = bits_r - mfr_pkg::BITS_W'(1);
                end else begin
                  phase_nxt = mfr_pkg::PH_READY;
                end
              end
            end
          endcase
        end
      end
      mfr_pkg::OP_ABORT: begin
        phase_nxt = mfr_pkg::PH_INVALID;
      end
      default: begin
        if (phase_r != mfr_pkg::PH_INVALID && phase_r != mfr_pkg::PH_READY &&
            cfg.master_mode && since_send > cfg.response_timeout_us) begin
          phase_nxt = mfr_pkg::PH_INVALID;
          ev_status = mfr_pkg::ST_TIMEOUT;
        end
      end
    endcase
  end

  mfr_classify u_classify (
    .frame_word (shift_nxt),
    .status     (cls_status)
  );

  always_comb begin
    res.phase = phase_nxt;
    if (phase_nxt == mfr_pkg::PH_READY) begin
      res.status     = cls_status;
      res.frame_word = shift_nxt;
    end else begin
      res.status     = ev_status;
      res.frame_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mfr_pkg::PH_INVALID;
      last_r  <= '0;
      bits_r  <= '0;
      shift_r <= '0;
      send_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      send_r  <= send_nxt;
    end
  end

endmodule
`default_nettype wire
